@@ design/spq_pkg.sv @@
// Package with shared types, codes and widths for the sorted priority queue.
package spq_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int ID_W   = 22;
    localparam int PRIO_W = 8;
    localparam int OCC_W  = 7;

    // Default number of queue slots.
    localparam int QUEUE_DEPTH_DEF = 64;

    typedef logic [ID_W-1:0]   proc_id_t;
    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [OCC_W-1:0]  occ_t;

    // Operation codes of a request transaction.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Status codes of a response transaction.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller state: whether a response is held in the output register.
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_HOLD = 1'b1
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_result;
        logic    do_insert;
        logic    do_remove;
        status_t result_status;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

@@ design/spq_if.sv @@
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
    import spq_pkg::*;

    logic     valid;
    logic     ready;
    op_t      op;
    proc_id_t proc_id;
    prio_t    prio;

    modport source (output valid, output op, output proc_id, output prio, input ready);
    modport sink   (input valid, input op, input proc_id, input prio, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic     valid;
    logic     ready;
    proc_id_t head_id;
    logic     head_valid;
    status_t  status;
    occ_t     occupancy;

    modport source (output valid, output head_id, output head_valid, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input head_id, input head_valid, input status,
                    input occupancy, output ready);
endinterface

@@ design/spq_ctrl.sv @@
// Controller of the sorted priority queue: handshakes and command decode.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  spq_pkg::op_t        req_op,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  spq_pkg::dp_status_t dp_status,
    output spq_pkg::ctl_cmd_t   cmd
);
    import spq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       accept;

    // A new request is taken when the output register is empty or being drained.
    assign req_ready = (state_reg == CTL_IDLE) || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                if (!accept && rsp_ready)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Outputs: response valid and the command for the accepted transaction.
    always_comb
    begin
        rsp_valid         = 1'b0;
        cmd.load_result   = accept;
        cmd.do_insert     = 1'b0;
        cmd.do_remove     = 1'b0;
        cmd.result_status = STATUS_OK;
        unique case (state_reg)
            CTL_IDLE: rsp_valid = 1'b0;
            CTL_HOLD: rsp_valid = 1'b1;
            default:  rsp_valid = 1'b0;
        endcase
        unique case (req_op)
            OP_INSERT:
            begin
                if (dp_status.full)
                begin
                    cmd.result_status = STATUS_FULL;
                end
                else
                begin
                    cmd.do_insert = accept;
                end
            end
            OP_REMOVE:
            begin
                if (dp_status.empty)
                begin
                    cmd.result_status = STATUS_EMPTY;
                end
                else
                begin
                    cmd.do_remove = accept;
                end
            end
            default:
            begin
                cmd.result_status = STATUS_OK;
            end
        endcase
    end

endmodule

@@ design/spq_datapath.sv @@
// Datapath of the sorted priority queue: shift-register slot chain and result register.
module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::ctl_cmd_t   cmd,
    input  spq_pkg::proc_id_t   proc_id,
    input  spq_pkg::prio_t      prio,
    output spq_pkg::dp_status_t dp_status,
    output spq_pkg::proc_id_t   head_id,
    output logic                head_valid,
    output spq_pkg::status_t    status,
    output spq_pkg::occ_t       occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Slot chain, head at index zero; contents above the fill count are don't care.
    proc_id_t         slot_id_reg   [QUEUE_DEPTH];
    prio_t            slot_prio_reg [QUEUE_DEPTH];
    proc_id_t         slot_id_next  [QUEUE_DEPTH];
    prio_t            slot_prio_next[QUEUE_DEPTH];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    // Slots that move back on insert: empty, or holding a strictly greater priority.
    logic [QUEUE_DEPTH-1:0] behind;

    proc_id_t head_id_reg;
    logic     head_valid_reg;
    status_t  status_reg;
    occ_t     occ_reg;

    assign dp_status.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign dp_status.empty = (fill_reg == '0);

    // Per-slot comparison against the incoming priority.
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            behind[k] = (CNT_W'(k) >= fill_reg) || (slot_prio_reg[k] > prio);
        end
    end

    // Next slot contents: each slot looks only at its neighbors.
    always_comb
    begin
        fill_next = fill_reg;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            slot_id_next[k]   = slot_id_reg[k];
            slot_prio_next[k] = slot_prio_reg[k];
        end
        if (cmd.do_insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
            for (int k = 0; k < QUEUE_DEPTH; k++)
            begin
                if (behind[k])
                begin
                    if (k == 0)
                    begin
                        slot_id_next[k]   = proc_id;
                        slot_prio_next[k] = prio;
                    end
                    else if (!behind[k-1])
                    begin
                        slot_id_next[k]   = proc_id;
                        slot_prio_next[k] = prio;
                    end
                    else
                    begin
                        slot_id_next[k]   = slot_id_reg[k-1];
                        slot_prio_next[k] = slot_prio_reg[k-1];
                    end
                end
            end
        end
        else if (cmd.do_remove)
        begin
            fill_next = fill_reg - CNT_W'(1);
            for (int k = 0; k < QUEUE_DEPTH - 1; k++)
            begin
                slot_id_next[k]   = slot_id_reg[k+1];
                slot_prio_next[k] = slot_prio_reg[k+1];
            end
        end
    end

    // Slot storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            slot_id_reg[k]   <= slot_id_next[k];
            slot_prio_reg[k] <= slot_prio_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Result register, loaded once per accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            head_id_reg    <= cmd.do_remove ? slot_id_reg[0] : '0;
            head_valid_reg <= cmd.do_remove;
            status_reg     <= cmd.result_status;
            occ_reg        <= OCC_W'(fill_next);
        end
    end

    assign head_id    = head_id_reg;
    assign head_valid = head_valid_reg;
    assign status     = status_reg;
    assign occupancy  = occ_reg;

endmodule

@@ design/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: controller, datapath and checks.
//
// A bounded priority queue of process identifiers kept in ascending priority
// order, lowest value at the head, equal priorities in first-in first-out order.
// The req channel carries one transaction per operation: op selects insert or
// remove, proc_id and prio give the entry to insert. The rsp channel returns
// exactly one transaction per request with head_id, head_valid, status and the
// occupancy after the operation. An insert into a full queue is dropped with the
// full status; a remove from an empty queue returns the empty status.
// The response is valid in the cycle after the request is accepted. Throughput
// is one transaction per cycle while the receiver does not stall, set by the
// slot chain, where every slot compares and shifts in parallel.
// The response sits in an output register; while the receiver stalls it holds,
// and req.ready is low until that response is taken (a new request is taken
// in the same cycle as the held response leaves).
// Reset empties the queue and clears any pending response; no clearing pass.
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    spq_req_if.sink      req,
    spq_rsp_if.source    rsp
);
    import spq_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t dp_status;

    // Handshake control and command decode.
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Slot chain and result register.
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .proc_id    (req.proc_id),
        .prio       (req.prio),
        .dp_status  (dp_status),
        .head_id    (rsp.head_id),
        .head_valid (rsp.head_valid),
        .status     (rsp.status),
        .occupancy  (rsp.occupancy)
    );

    // Every accepted request produces a response in the next cycle.
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("accepted request produced no response");

    // A returned entry always comes with the ok status.
    a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.head_valid) |-> (rsp.status == STATUS_OK))
        else $error("head entry returned with an error status");

    // A remove on an empty queue reports nothing held, no identifier and zero occupancy.
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_EMPTY)
            |-> (rsp.head_id == '0 && !rsp.head_valid && rsp.occupancy == '0))
        else $error("empty response carries data");

    // The command decode never both inserts and removes.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_insert && cmd.do_remove))
        else $error("insert and remove issued together");

endmodule
